### design/imucc_pkg.sv
`default_nettype none

package imucc_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SLICE_BITS     = 16;
  localparam int NUM_AXES       = 3;
  localparam int CFG_W          = NUM_AXES * SLICE_BITS;
  localparam int CFG_IDX_W      = 3;
  localparam int EN_W           = 4;

  // scale product: sample times zero-extended unsigned coefficient
  localparam int SPRD_W = SAMPLE_WIDTH + SLICE_BITS + 1;
  // rotation product: sample times signed coefficient
  localparam int MUL_W  = SAMPLE_WIDTH + SLICE_BITS;
  // working width for sums, rounding and saturation
  localparam int SAT_W  = MUL_W + 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SAT_W-1:0]        wide_t;
  typedef logic [SLICE_BITS-1:0]          coef_t;
  typedef logic [CFG_W-1:0]               cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [EN_W-1:0]                en_t;

  localparam cfg_idx_t CFG_ENABLE    = 3'd0;
  localparam cfg_idx_t CFG_ACC_BIAS  = 3'd1;
  localparam cfg_idx_t CFG_ACC_SCALE = 3'd2;
  localparam cfg_idx_t CFG_GYRO_BIAS = 3'd3;
  localparam cfg_idx_t CFG_ROT_ROW0  = 3'd4;
  localparam cfg_idx_t CFG_ROT_ROW1  = 3'd5;
  localparam cfg_idx_t CFG_ROT_ROW2  = 3'd6;

  localparam int EN_ACC_BIAS  = 0;
  localparam int EN_ACC_SCALE = 1;
  localparam int EN_GYRO_BIAS = 2;
  localparam int EN_ROTATE    = 3;

  localparam coef_t     COEF_ONE      = coef_t'(1) << COEF_FRAC_BITS;
  localparam coef_t     COEF_ZERO     = '0;
  localparam cfg_word_t ACC_SCALE_RST = {COEF_ONE, COEF_ONE, COEF_ONE};
  localparam cfg_word_t ROT_ROW0_RST  = {COEF_ZERO, COEF_ZERO, COEF_ONE};
  localparam cfg_word_t ROT_ROW1_RST  = {COEF_ZERO, COEF_ONE, COEF_ZERO};
  localparam cfg_word_t ROT_ROW2_RST  = {COEF_ONE, COEF_ZERO, COEF_ZERO};

  localparam wide_t SAT_HI   = {{(SAT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam wide_t SAT_LO   = ~SAT_HI;
  localparam wide_t RND_HALF = wide_t'(1) << (COEF_FRAC_BITS - 1);

  function automatic sample_t sat(input wide_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  // round to nearest, ties up: floor((v + half) / 2^F)
  function automatic sample_t round_sat(input wide_t v);
    wide_t t;
    t = (v + RND_HALF) >>> COEF_FRAC_BITS;
    return sat(t);
  endfunction

  function automatic coef_t slice(input cfg_word_t w, input int k);
    return w[k*SLICE_BITS +: SLICE_BITS];
  endfunction

endpackage

`default_nettype wire

### design/imu_sample_calibration_correct_unit.sv
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_acc_x..z, in_gyro_x..z (16 b signed)
//  out_     output     out_valid / out_stall  out_acc_x..z, out_gyro_x..z (16 b signed)
//  cfg_     input      cfg_valid / cfg_ready  cfg_index (3 b), cfg_wdata (48 b)
//
//  Five register stages: bias subtract, scale multiply, scale round, rotation
//  multiply, rotation sum and round. One transaction per cycle while out_stall is low.
//  Synchronous active-low reset clears the valid bits and loads the register defaults.
//  Each stage loads when empty or when the stage after it moves, so bubbles are
//  squeezed out and in_stall rises only when all five stages hold data and out_stall is high.
//  cfg_ready is always high.
`default_nettype none

module imu_sample_calibration_correct_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_acc_x,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_acc_y,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_acc_z,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_gyro_x,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_gyro_y,
  input  wire  signed [imucc_pkg::SAMPLE_WIDTH-1:0] in_gyro_z,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_acc_x,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_acc_y,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_acc_z,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_gyro_x,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_gyro_y,
  output logic signed [imucc_pkg::SAMPLE_WIDTH-1:0] out_gyro_z,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [imucc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [imucc_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int N = imucc_pkg::NUM_AXES;

  // configuration registers
  imucc_pkg::en_t       en_r;
  imucc_pkg::cfg_word_t acc_bias_r;
  imucc_pkg::cfg_word_t acc_scale_r;
  imucc_pkg::cfg_word_t gyro_bias_r;
  imucc_pkg::cfg_word_t rot_row_r [N];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= '0;
      acc_bias_r   <= '0;
      acc_scale_r  <= imucc_pkg::ACC_SCALE_RST;
      gyro_bias_r  <= '0;
      rot_row_r[0] <= imucc_pkg::ROT_ROW0_RST;
      rot_row_r[1] <= imucc_pkg::ROT_ROW1_RST;
      rot_row_r[2] <= imucc_pkg::ROT_ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imucc_pkg::CFG_ENABLE:    en_r         <= cfg_wdata[imucc_pkg::EN_W-1:0];
        imucc_pkg::CFG_ACC_BIAS:  acc_bias_r   <= cfg_wdata;
        imucc_pkg::CFG_ACC_SCALE: acc_scale_r  <= cfg_wdata;
        imucc_pkg::CFG_GYRO_BIAS: gyro_bias_r  <= cfg_wdata;
        imucc_pkg::CFG_ROT_ROW0:  rot_row_r[0] <= cfg_wdata;
        imucc_pkg::CFG_ROT_ROW1:  rot_row_r[1] <= cfg_wdata;
        imucc_pkg::CFG_ROT_ROW2:  rot_row_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline valid bits and flow control
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !s4_valid_r || rdy5;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_valid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) s4_valid_r  <= s3_valid_r;
      if (rdy5) out_valid_r <= s4_valid_r;
    end
  end

  // payload registers
  imucc_pkg::sample_t in_acc [N];
  imucc_pkg::sample_t in_gyro [N];

  imucc_pkg::sample_t s1_acc_r [N], s1_acc_nxt [N];
  imucc_pkg::sample_t s1_gyro_r [N], s1_gyro_nxt [N];
  logic signed [imucc_pkg::SPRD_W-1:0] s2_prod_r [N], s2_prod_nxt [N];
  imucc_pkg::sample_t s2_acc_r [N];
  imucc_pkg::sample_t s2_gyro_r [N];
  imucc_pkg::sample_t s3_acc_r [N], s3_acc_nxt [N];
  imucc_pkg::sample_t s3_gyro_r [N];
  logic signed [imucc_pkg::MUL_W-1:0] s4_prod_r [N][N], s4_prod_nxt [N][N];
  imucc_pkg::sample_t s4_acc_r [N];
  imucc_pkg::sample_t s4_gyro_r [N];
  imucc_pkg::sample_t out_acc_r [N], out_acc_nxt [N];
  imucc_pkg::sample_t out_gyro_r [N];

  assign in_acc[0]  = in_acc_x;
  assign in_acc[1]  = in_acc_y;
  assign in_acc[2]  = in_acc_z;
  assign in_gyro[0] = in_gyro_x;
  assign in_gyro[1] = in_gyro_y;
  assign in_gyro[2] = in_gyro_z;

  // stage 1: bias subtract
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (en_r[imucc_pkg::EN_ACC_BIAS]) begin
        s1_acc_nxt[i] = imucc_pkg::sat(imucc_pkg::wide_t'(in_acc[i]) -
          imucc_pkg::wide_t'($signed(imucc_pkg::slice(acc_bias_r, i))));
      end else begin
        s1_acc_nxt[i] = in_acc[i];
      end
      if (en_r[imucc_pkg::EN_GYRO_BIAS]) begin
        s1_gyro_nxt[i] = imucc_pkg::sat(imucc_pkg::wide_t'(in_gyro[i]) -
          imucc_pkg::wide_t'($signed(imucc_pkg::slice(gyro_bias_r, i))));
      end else begin
        s1_gyro_nxt[i] = in_gyro[i];
      end
    end
  end

  // stage 2: scale multiply
  always_comb begin
    for (int i = 0; i < N; i++) begin
      s2_prod_nxt[i] = imucc_pkg::SPRD_W'(s1_acc_r[i] *
        $signed({1'b0, imucc_pkg::slice(acc_scale_r, i)}));
    end
  end

  // stage 3: scale round and saturate
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (en_r[imucc_pkg::EN_ACC_SCALE]) begin
        s3_acc_nxt[i] = imucc_pkg::round_sat(imucc_pkg::wide_t'(s2_prod_r[i]));
      end else begin
        s3_acc_nxt[i] = s2_acc_r[i];
      end
    end
  end

  // stage 4: rotation products
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        s4_prod_nxt[i][j] = imucc_pkg::MUL_W'(s3_acc_r[j] *
          $signed(imucc_pkg::slice(rot_row_r[i], j)));
      end
    end
  end

  // stage 5: row sum, round, saturate
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (en_r[imucc_pkg::EN_ROTATE]) begin
        out_acc_nxt[i] = imucc_pkg::round_sat(imucc_pkg::wide_t'(s4_prod_r[i][0]) +
          imucc_pkg::wide_t'(s4_prod_r[i][1]) + imucc_pkg::wide_t'(s4_prod_r[i][2]));
      end else begin
        out_acc_nxt[i] = s4_acc_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_acc_r  <= s1_acc_nxt;
      s1_gyro_r <= s1_gyro_nxt;
    end
    if (rdy2) begin
      s2_prod_r <= s2_prod_nxt;
      s2_acc_r  <= s1_acc_r;
      s2_gyro_r <= s1_gyro_r;
    end
    if (rdy3) begin
      s3_acc_r  <= s3_acc_nxt;
      s3_gyro_r <= s2_gyro_r;
    end
    if (rdy4) begin
      s4_prod_r <= s4_prod_nxt;
      s4_acc_r  <= s3_acc_r;
      s4_gyro_r <= s3_gyro_r;
    end
    if (rdy5) begin
      out_acc_r  <= out_acc_nxt;
      out_gyro_r <= s4_gyro_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_acc_x  = out_acc_r[0];
  assign out_acc_y  = out_acc_r[1];
  assign out_acc_z  = out_acc_r[2];
  assign out_gyro_x = out_gyro_r[0];
  assign out_gyro_y = out_gyro_r[1];
  assign out_gyro_z = out_gyro_r[2];

  // stall only with a full pipe held from downstream
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s3_valid_r && s4_valid_r &&
                  out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (en_r == '0 && !out_valid_r && !s1_valid_r))
    else $error("reset did not clear control state");

  a_gyro_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !en_r[imucc_pkg::EN_GYRO_BIAS]) |=>
      (s1_gyro_r[0] == $past(in_gyro_x) && s1_gyro_r[2] == $past(in_gyro_z)))
    else $error("gyro altered with bias correction off");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s4_valid_r) |=> !out_valid_r)
    else $error("output transaction repeated");

endmodule

`default_nettype wire

### verif/tb_imu_sample_calibration_correct_unit.sv
module tb_imu_sample_calibration_correct_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imucc_pkg::*;

  typedef struct packed {
    sample_t [NUM_AXES-1:0] acc;
    sample_t [NUM_AXES-1:0] gyro;
  } imu_sample_t;

  localparam cfg_idx_t CFG_UNUSED      = 3'd7;
  localparam int       PIPE_DEPTH      = 5;
  localparam int       ITEMS_PER_PHASE = 120;
  localparam int       RANDOM_PHASES   = 12;
  localparam int       MAX_PRINTED     = 50;
  localparam longint   SAMPLE_MAX      = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint   SAMPLE_MIN      = -SAMPLE_MAX - 1;
  localparam longint   ROUND_HALF      = longint'(1) <<< (COEF_FRAC_BITS - 1);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  imu_sample_t drive_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sample_t     out_acc_x, out_acc_y, out_acc_z;
  sample_t     out_gyro_x, out_gyro_y, out_gyro_z;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_ENABLE;
  cfg_word_t   cfg_wdata = '0;

  // register copies, updated on every accepted config write
  en_t       en_model;
  cfg_word_t acc_bias_model, acc_scale_model, gyro_bias_model;
  cfg_word_t rot_model [NUM_AXES];

  imu_sample_t raw_samples_pending [$];
  imu_sample_t corrected_expected [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_sender = 1'b0;

  imu_sample_calibration_correct_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_acc_x   (drive_item.acc[0]),
    .in_acc_y   (drive_item.acc[1]),
    .in_acc_z   (drive_item.acc[2]),
    .in_gyro_x  (drive_item.gyro[0]),
    .in_gyro_y  (drive_item.gyro[1]),
    .in_gyro_z  (drive_item.gyro[2]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_acc_x  (out_acc_x),
    .out_acc_y  (out_acc_y),
    .out_acc_z  (out_acc_z),
    .out_gyro_x (out_gyro_x),
    .out_gyro_y (out_gyro_y),
    .out_gyro_z (out_gyro_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_sample(input longint v);
    if (v > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end
    if (v < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return v;
  endfunction

  // nearest, ties towards plus infinity
  function automatic longint round_coef(input longint v);
    return (v + ROUND_HALF) >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint signed_coef(input cfg_word_t w, input int k);
    return longint'($signed(w[k*SLICE_BITS +: SLICE_BITS]));
  endfunction

  function automatic imu_sample_t correct_sample(input imu_sample_t raw);
    longint      acc [NUM_AXES];
    longint      gyr [NUM_AXES];
    longint      rot [NUM_AXES];
    longint      sum;
    imu_sample_t res;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc[i] = longint'($signed(raw.acc[i]));
      gyr[i] = longint'($signed(raw.gyro[i]));
      if (en_model[EN_ACC_BIAS]) begin
        acc[i] = clamp_sample(acc[i] - signed_coef(acc_bias_model, i));
      end
      if (en_model[EN_ACC_SCALE]) begin
        acc[i] = clamp_sample(round_coef(
                   acc[i] * longint'(acc_scale_model[i*SLICE_BITS +: SLICE_BITS])));
      end
      if (en_model[EN_GYRO_BIAS]) begin
        gyr[i] = clamp_sample(gyr[i] - signed_coef(gyro_bias_model, i));
      end
    end
    if (en_model[EN_ROTATE]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sum = 0;
        for (int j = 0; j < NUM_AXES; j++) begin
          sum += signed_coef(rot_model[i], j) * acc[j];
        end
        rot[i] = clamp_sample(round_coef(sum));
      end
      acc = rot;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      res.acc[i]  = sample_t'(acc[i]);
      res.gyro[i] = sample_t'(gyr[i]);
    end
    return res;
  endfunction

  function automatic imu_sample_t mk_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz);
    imu_sample_t s;
    s.acc[0]  = sample_t'(ax);
    s.acc[1]  = sample_t'(ay);
    s.acc[2]  = sample_t'(az);
    s.gyro[0] = sample_t'(gx);
    s.gyro[1] = sample_t'(gy);
    s.gyro[2] = sample_t'(gz);
    return s;
  endfunction

  function automatic sample_t rand_field();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return sample_t'(16'h7FFF);
    end
    if (pick == 1) begin
      return sample_t'(16'h8000);
    end
    if (pick < 4) begin
      return sample_t'(int'($urandom_range(600)) - 300);
    end
    return sample_t'($urandom);
  endfunction

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    for (int i = 0; i < NUM_AXES; i++) begin
      s.acc[i]  = rand_field();
      s.gyro[i] = rand_field();
    end
    return s;
  endfunction

  function automatic cfg_word_t rand_coef_word();
    cfg_word_t w;
    coef_t     c;
    for (int k = 0; k < NUM_AXES; k++) begin
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(3))
            0:       c = 16'h0000;
            1:       c = 16'hFFFF;
            2:       c = 16'h7FFF;
            default: c = 16'h8000;
          endcase
        end
        1:       c = COEF_ONE + coef_t'($urandom_range(2000)) - coef_t'(1000);
        default: c = coef_t'($urandom);
      endcase
      w[k*SLICE_BITS +: SLICE_BITS] = c;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // must be entered just after a rising edge; leaves cfg_valid high
  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic apply_config(input cfg_word_t en, input cfg_word_t ab, input cfg_word_t sc,
                              input cfg_word_t gb, input cfg_word_t r0, input cfg_word_t r1,
                              input cfg_word_t r2, input bit poke_unused);
    @(posedge clk);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_ACC_BIAS, ab);
    write_reg(CFG_ACC_SCALE, sc);
    write_reg(CFG_GYRO_BIAS, gb);
    write_reg(CFG_ROT_ROW0, r0);
    write_reg(CFG_ROT_ROW1, r1);
    write_reg(CFG_ROT_ROW2, r2);
    if (poke_unused) begin
      write_reg(CFG_UNUSED, cfg_word_t'({$urandom, $urandom}));
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (raw_samples_pending.size() != 0 || in_valid || corrected_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 85;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 85;
      end
      default: begin
        send_idle_pct  = 6;
        recv_stall_pct = 6;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      en_model        <= '0;
      acc_bias_model  <= '0;
      acc_scale_model <= ACC_SCALE_RST;
      gyro_bias_model <= '0;
      rot_model[0]    <= ROT_ROW0_RST;
      rot_model[1]    <= ROT_ROW1_RST;
      rot_model[2]    <= ROT_ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:    en_model        <= cfg_wdata[EN_W-1:0];
        CFG_ACC_BIAS:  acc_bias_model  <= cfg_wdata;
        CFG_ACC_SCALE: acc_scale_model <= cfg_wdata;
        CFG_GYRO_BIAS: gyro_bias_model <= cfg_wdata;
        CFG_ROT_ROW0:  rot_model[0]    <= cfg_wdata;
        CFG_ROT_ROW1:  rot_model[1]    <= cfg_wdata;
        CFG_ROT_ROW2:  rot_model[2]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        corrected_expected.push_back(correct_sample(drive_item));
      end
      if (!in_valid || !in_stall) begin
        if (raw_samples_pending.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          drive_item <= raw_samples_pending.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    imu_sample_t seen;
    imu_sample_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_acc_z, out_acc_y, out_acc_x, out_gyro_z, out_gyro_y, out_gyro_x};
        if (corrected_expected.size() == 0) begin
          report_mismatch($sformatf("transaction with nothing pending, acc %0d %0d %0d",
                                    out_acc_x, out_acc_y, out_acc_z));
        end else begin
          want = corrected_expected.pop_front();
          for (int k = 0; k < NUM_AXES; k++) begin
            if (seen.acc[k] !== want.acc[k]) begin
              report_mismatch($sformatf("acc axis %0d: expected %0d, got %0d", k,
                                        $signed(want.acc[k]), $signed(seen.acc[k])));
            end
            if (seen.gyro[k] !== want.gyro[k]) begin
              report_mismatch($sformatf("gyro axis %0d: expected %0d, got %0d", k,
                                        $signed(want.gyro[k]), $signed(seen.gyro[k])));
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    cfg_word_t en_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, all corrections off: straight pass-through
    set_idling(0);
    raw_samples_pending.push_back(mk_sample(32767, 32767, 32767, 32767, 32767, 32767));
    raw_samples_pending.push_back(mk_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    raw_samples_pending.push_back(mk_sample(0, 0, 0, 0, 0, 0));
    raw_samples_pending.push_back(mk_sample(-1, -1, -1, -1, -1, -1));
    raw_samples_pending.push_back(mk_sample(21845, -21846, 21845, -21846, 21845, -21846));
    wait_drained();

    // everything on, other registers still at reset: identity
    @(posedge clk);
    write_reg(CFG_ENABLE, cfg_word_t'(4'hF));
    cfg_valid <= 1'b0;
    @(negedge clk);
    raw_samples_pending.push_back(mk_sample(32767, -32768, 1, -32768, 32767, -1));
    raw_samples_pending.push_back(mk_sample(100, -200, 300, -400, 500, -600));
    wait_drained();

    // oversized enable word, bias and scale corners, rounding ties on z
    apply_config(48'hFFFF_FFFF_FFFF, 48'h0001_7FFF_8000, 48'h2000_0000_FFFF,
                 48'hFFFF_8000_7FFF, ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST, 1'b1);
    set_idling(1);
    raw_samples_pending.push_back(mk_sample(32767, 0, 4, -32768, 32767, 0));
    raw_samples_pending.push_back(mk_sample(-32768, -32768, -2, 32767, -32768, -32768));
    raw_samples_pending.push_back(mk_sample(1, 100, 2, 0, 0, 32767));
    raw_samples_pending.push_back(mk_sample(-1, -1, 0, -1, 1, 5));
    raw_samples_pending.push_back(mk_sample(0, 0, -32768, 12345, -12345, -1));
    wait_drained();

    // scale and full-scale rotation, gyro bias loaded but disabled
    en_word = '0;
    en_word[EN_ACC_SCALE] = 1'b1;
    en_word[EN_ROTATE]    = 1'b1;
    apply_config(en_word, 48'h0000_0000_0000, 48'h4000_6000_3000, 48'h1234_8000_7FFF,
                 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'hC000_7FFF_8000, 1'b0);
    set_idling(2);
    raw_samples_pending.push_back(mk_sample(32767, 32767, 32767, 1, 2, 3));
    raw_samples_pending.push_back(mk_sample(-32768, -32768, -32768, -1, -2, -3));
    raw_samples_pending.push_back(mk_sample(32767, -32768, 1, 32767, -32768, 0));
    raw_samples_pending.push_back(mk_sample(3, -5, 7, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_config(48'hFFFF_FFFF_FFFF, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                     {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 1'b0);
      end else if (ph == 1) begin
        apply_config(48'h0000_0000_000F, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                     {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 1'b0);
      end else begin
        en_word = '0;
        if (ph < 6) begin
          en_word[ph-2] = 1'b1;
        end else begin
          en_word = cfg_word_t'({$urandom, $urandom});
        end
        apply_config(en_word, rand_coef_word(), rand_coef_word(), rand_coef_word(),
                     rand_coef_word(), rand_coef_word(), rand_coef_word(), ph == 8);
      end
      set_idling(ph % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        raw_samples_pending.push_back(rand_sample());
      end
      if (ph == 7) begin
        // pause mid-stream until the pipeline has emptied completely
        while (raw_samples_pending.size() > ITEMS_PER_PHASE / 2) begin
          @(negedge clk);
        end
        hold_sender = 1'b1;
        while (in_valid || corrected_expected.size() != 0) begin
          @(negedge clk);
        end
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    repeat (PIPE_DEPTH + 3) @(posedge clk);
    if (mismatch_count == 0 && corrected_expected.size() == 0) begin
      $display("imu_sample_calibration_correct_unit verification clean");
    end else begin
      $display("imu_sample_calibration_correct_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("imu_sample_calibration_correct_unit verification failed");
    $finish;
  end

endmodule

### files.f
design/imucc_pkg.sv
design/imu_sample_calibration_correct_unit.sv
verif/tb_imu_sample_calibration_correct_unit.sv
